### rtl/core/mck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Morse keyer shared definitions
// Types, register indexes, character codes and the dot/dash pattern table
// used by the Morse keyer modules.
// ============================================================================
package mck_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 256;
    localparam int DEFAULT_TICK_WIDTH = 16;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CHAR_WIDTH      = 8;
    localparam int LEVEL_WIDTH     = 9;

    // Operation codes of an input beat.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOT_TICKS        = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DASH_TICKS       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYMBOL_GAP_TICKS = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LETTER_GAP_TICKS = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WORD_GAP_TICKS   = 3'd4;

    // Register values after reset.
    localparam logic [CFG_WIDTH-1:0] RESET_DOT_TICKS        = 16'd200;
    localparam logic [CFG_WIDTH-1:0] RESET_DASH_TICKS       = 16'd600;
    localparam logic [CFG_WIDTH-1:0] RESET_SYMBOL_GAP_TICKS = 16'd200;
    localparam logic [CFG_WIDTH-1:0] RESET_LETTER_GAP_TICKS = 16'd600;
    localparam logic [CFG_WIDTH-1:0] RESET_WORD_GAP_TICKS   = 16'd1400;

    // ASCII codes that bound the character classes.
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;

    localparam int GLYPH_COUNT = 36;
    localparam int GLYPH_INDEX_WIDTH = 6;
    localparam logic [GLYPH_INDEX_WIDTH-1:0] DIGIT_BASE = 6'd26;

    // Bits 7..5 hold the symbol count, bits 4..0 the pattern with symbol i in
    // bit i (1 = dash). Letters A to Z come first, then digits 0 to 9.
    localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80,
        8'h40, 8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86,
        8'h8B, 8'h62, 8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89,
        8'h8D, 8'h83,
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3,
        8'hA7, 8'hAF
    };

    typedef struct packed {
        logic [CFG_WIDTH-1:0] dot_ticks;
        logic [CFG_WIDTH-1:0] dash_ticks;
        logic [CFG_WIDTH-1:0] symbol_gap_ticks;
        logic [CFG_WIDTH-1:0] letter_gap_ticks;
        logic [CFG_WIDTH-1:0] word_gap_ticks;
    } mck_cfg_t;

    typedef struct packed {
        logic push;
        logic pop;
    } mck_fifo_ctl_t;

    typedef struct packed {
        logic                   key_on;
        logic                   accepted;
        logic                   busy_res;
        logic [LEVEL_WIDTH-1:0] fifo_level;
    } mck_result_t;

    typedef struct packed {
        logic       is_glyph;
        logic       is_space;
        logic [4:0] bits;
        logic [2:0] len;
    } mck_glyph_t;

    // Sorts a character into letter/digit, space or other, and looks up the
    // pattern of letters and digits.
    function automatic mck_glyph_t mck_classify(input logic [CHAR_WIDTH-1:0] c);
        mck_glyph_t                   g;
        logic [GLYPH_INDEX_WIDTH-1:0] idx;
        logic [7:0]                   entry;
        g   = '0;
        idx = '0;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            g.is_glyph = 1'b1;
            idx = GLYPH_INDEX_WIDTH'(c - CHAR_UPPER_A);
        end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            g.is_glyph = 1'b1;
            idx = GLYPH_INDEX_WIDTH'(c - CHAR_LOWER_A);
        end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
            g.is_glyph = 1'b1;
            idx = GLYPH_INDEX_WIDTH'(c - CHAR_DIGIT_0) + DIGIT_BASE;
        end else if (c == CHAR_SPACE) begin
            g.is_space = 1'b1;
        end
        entry  = GLYPHS[idx];
        g.bits = entry[4:0];
        g.len  = entry[7:5];
        return g;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mck_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and returns the
// contents from before a write to the same address in the same cycle.
// ============================================================================
module mck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_WIDTH-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic [ADDR_WIDTH-1:0] rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mck_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Morse keyer character FIFO
// Ring buffer in a RAM with read and write pointers and a fill count. The
// byte at the head is always presented, with a bypass for a byte written to
// the address being read.
// ============================================================================
module mck_fifo
    import mck_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mck_fifo_ctl_t          ctl,
    input  wire logic [CHAR_WIDTH-1:0]  push_data,
    output logic      [CHAR_WIDTH-1:0]  head,
    output logic      [COUNT_WIDTH-1:0] count
);

    localparam int PTR_WIDTH = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   bypass_reg, bypass_next;
    logic [CHAR_WIDTH-1:0]  bypass_data_reg;
    logic [CHAR_WIDTH-1:0]  ram_q;

    function automatic logic [PTR_WIDTH-1:0] ptr_inc(input logic [PTR_WIDTH-1:0] p);
        logic [PTR_WIDTH:0] sum;
        sum = {1'b0, p} + (PTR_WIDTH + 1)'(1);
        if (sum >= (PTR_WIDTH + 1)'(FIFO_DEPTH))
        begin
            return '0;
        end
        return sum[PTR_WIDTH-1:0];
    endfunction

    always_comb
    begin
        wr_ptr_next = ctl.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + COUNT_WIDTH'(ctl.push) - COUNT_WIDTH'(ctl.pop);
        // The RAM returns old contents when the slot being read is written in
        // the same cycle, so that byte is kept aside.
        bypass_next = ctl.push && (wr_ptr_reg == rd_ptr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= push_data;
    end

    mck_ram #(
        .WIDTH (CHAR_WIDTH),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctl.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_data),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_q)
    );

    assign head  = bypass_reg ? bypass_data_reg : ram_q;
    assign count = count_reg;

endmodule
`default_nettype wire

### rtl/core/mck_keyer.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Morse keyer sequencer
// Interval countdown and letter state; decides FIFO push and pop and forms
// the result of each beat from the updated state.
// ============================================================================
module mck_keyer
    import mck_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    parameter int TICK_WIDTH = DEFAULT_TICK_WIDTH,
    localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   opcode,
    input  wire logic                   last_of_write,
    input  wire mck_cfg_t               cfg,
    input  wire logic [COUNT_WIDTH-1:0] fifo_count,
    input  wire logic [CHAR_WIDTH-1:0]  fifo_head,
    output mck_fifo_ctl_t               fifo_ctl,
    output mck_result_t                 result
);

    logic                   sending_reg, sending_next;
    logic                   keyed_reg, keyed_next;
    logic                   in_letter_reg, in_letter_next;
    logic [4:0]             pattern_bits_reg, pattern_bits_next;
    logic [2:0]             pattern_len_reg, pattern_len_next;
    logic [2:0]             symbol_index_reg, symbol_index_next;
    logic [TICK_WIDTH-1:0]  countdown_reg, countdown_next;

    mck_glyph_t             glyph;
    logic [7:0]             pattern_ext;
    logic                   dash_now;
    logic [TICK_WIDTH-1:0]  countdown_dec;
    logic                   has_room;
    logic                   accepted;
    logic [COUNT_WIDTH-1:0] level_next;
    logic [31:0]            level_wide;

    // A zero setting counts as one tick; a setting beyond the counter range
    // saturates to the largest count.
    function automatic logic [TICK_WIDTH-1:0] load_ticks(input logic [CFG_WIDTH-1:0] v);
        logic [32:0] wide;
        logic [32:0] tick_max;
        wide     = 33'(v);
        tick_max = (33'd1 << TICK_WIDTH) - 33'd1;
        if (v == '0)
        begin
            return TICK_WIDTH'(1);
        end
        if (wide > tick_max)
        begin
            return '1;
        end
        return wide[TICK_WIDTH-1:0];
    endfunction

    always_comb
    begin
        sending_next      = sending_reg;
        keyed_next        = keyed_reg;
        in_letter_next    = in_letter_reg;
        pattern_bits_next = pattern_bits_reg;
        pattern_len_next  = pattern_len_reg;
        symbol_index_next = symbol_index_reg;
        countdown_next    = countdown_reg;
        fifo_ctl          = '0;
        accepted          = 1'b0;

        glyph         = mck_classify(fifo_head);
        pattern_ext   = {3'b000, pattern_bits_reg};
        dash_now      = pattern_ext[symbol_index_reg];
        countdown_dec = (countdown_reg == '0) ? '0 : countdown_reg - TICK_WIDTH'(1);
        has_room      = fifo_count < COUNT_WIDTH'(FIFO_DEPTH);

        if (step)
        begin
            if (opcode == OP_WRITE)
            begin
                if (has_room)
                begin
                    fifo_ctl.push = 1'b1;
                    accepted      = 1'b1;
                end
                // A refused last byte still starts sending if data is queued.
                if (last_of_write && !sending_reg && (has_room || fifo_count != '0))
                begin
                    sending_next   = 1'b1;
                    countdown_next = TICK_WIDTH'(1);
                end
            end
            else if (sending_reg)
            begin
                countdown_next = countdown_dec;
                if (countdown_dec == '0)
                begin
                    if (!in_letter_reg)
                    begin
                        if (fifo_count == '0)
                        begin
                            sending_next = 1'b0;
                            keyed_next   = 1'b0;
                        end
                        else
                        begin
                            fifo_ctl.pop = 1'b1;
                            if (glyph.is_glyph)
                            begin
                                pattern_bits_next = glyph.bits;
                                pattern_len_next  = glyph.len;
                                symbol_index_next = 3'd1;
                                in_letter_next    = 1'b1;
                                keyed_next        = 1'b1;
                                countdown_next    = load_ticks(glyph.bits[0] ?
                                                    cfg.dash_ticks : cfg.dot_ticks);
                            end
                            else if (glyph.is_space)
                            begin
                                keyed_next     = 1'b0;
                                countdown_next = load_ticks(cfg.word_gap_ticks);
                            end
                            else
                            begin
                                countdown_next = TICK_WIDTH'(1);
                            end
                        end
                    end
                    else if (keyed_reg)
                    begin
                        keyed_next     = 1'b0;
                        countdown_next = load_ticks(cfg.symbol_gap_ticks);
                    end
                    else if (symbol_index_reg >= pattern_len_reg)
                    begin
                        in_letter_next = 1'b0;
                        countdown_next = load_ticks(cfg.letter_gap_ticks);
                    end
                    else
                    begin
                        keyed_next        = 1'b1;
                        symbol_index_next = symbol_index_reg + 3'd1;
                        countdown_next    = load_ticks(dash_now ?
                                            cfg.dash_ticks : cfg.dot_ticks);
                    end
                end
            end
        end

        level_next = fifo_count + COUNT_WIDTH'(fifo_ctl.push) - COUNT_WIDTH'(fifo_ctl.pop);
        level_wide = 32'(level_next);

        result.key_on     = keyed_next;
        result.accepted   = accepted;
        result.busy_res   = sending_next;
        result.fifo_level = level_wide[LEVEL_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg      <= 1'b0;
            keyed_reg        <= 1'b0;
            in_letter_reg    <= 1'b0;
            pattern_bits_reg <= '0;
            pattern_len_reg  <= '0;
            symbol_index_reg <= '0;
            countdown_reg    <= '0;
        end
        else
        begin
            sending_reg      <= sending_next;
            keyed_reg        <= keyed_next;
            in_letter_reg    <= in_letter_next;
            pattern_bits_reg <= pattern_bits_next;
            pattern_len_reg  <= pattern_len_next;
            symbol_index_reg <= symbol_index_next;
            countdown_reg    <= countdown_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/morse_code_keyer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Morse code keyer unit
// Character FIFO feeding a Morse keyer that is clocked by tick beats.
// ============================================================================
// The unit takes one input beat per clock cycle and returns exactly one result
// beat for each, in the cycle after acceptance; a beat is taken whenever the
// result register is empty or is being drained in the same cycle, so the
// sustained rate is one item per cycle. A write beat (opcode 0) queues
// char_byte in a FIFO of FIFO_DEPTH characters held in a RAM; accepted tells
// whether it fit, and a beat marked last_of_write starts sending when the
// keyer is idle and the FIFO holds data. A tick beat (opcode 1) counts down
// the current interval; when it runs out the keyer pops the next character
// and keys its dots and dashes, separated by symbol gaps and followed by a
// letter gap. A space keys off for the word gap, any other character waits
// one tick, and an empty FIFO ends sending. Every result reports the key
// state, whether the keyer is busy and the FIFO level after the beat. The
// FIFO head is read from a registered RAM port addressed by the next read
// pointer, with a bypass for a byte written into that slot, so no clearing
// pass follows reset. The user must write the five timing registers through
// the cfg_write port only while the unit is idle; the block does not enforce
// this. All durations are in ticks, a zero setting acts as one tick, and
// settings beyond a TICK_WIDTH-bit counter saturate.
// ============================================================================
module morse_code_keyer_unit
    import mck_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    parameter int TICK_WIDTH = DEFAULT_TICK_WIDTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input channel.
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic                       opcode,
    input  wire logic [CHAR_WIDTH-1:0]      char_byte,
    input  wire logic                       last_of_write,
    // Result channel.
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic                            key_on,
    output logic                            accepted,
    output logic                            busy_res,
    output logic      [LEVEL_WIDTH-1:0]     fifo_level,
    // Configuration write port.
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

    localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    mck_cfg_t               cfg_reg, cfg_next;
    logic                   result_valid_reg, result_valid_next;
    mck_result_t            result_reg;
    mck_result_t            step_result;
    mck_fifo_ctl_t          fifo_ctl;
    logic [COUNT_WIDTH-1:0] fifo_count;
    logic [CHAR_WIDTH-1:0]  fifo_head;
    logic                   step;

    // The result register parts the two channels: a new beat is taken when no
    // result is pending or the pending result leaves in the same cycle.
    assign item_ready = !result_valid_reg || result_ready;
    assign step       = item_valid && item_ready;

    // Timing register writes; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DOT_TICKS:        cfg_next.dot_ticks        = cfg_data;
                CFG_DASH_TICKS:       cfg_next.dash_ticks       = cfg_data;
                CFG_SYMBOL_GAP_TICKS: cfg_next.symbol_gap_ticks = cfg_data;
                CFG_LETTER_GAP_TICKS: cfg_next.letter_gap_ticks = cfg_data;
                CFG_WORD_GAP_TICKS:   cfg_next.word_gap_ticks   = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (step)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_ticks        <= RESET_DOT_TICKS;
            cfg_reg.dash_ticks       <= RESET_DASH_TICKS;
            cfg_reg.symbol_gap_ticks <= RESET_SYMBOL_GAP_TICKS;
            cfg_reg.letter_gap_ticks <= RESET_LETTER_GAP_TICKS;
            cfg_reg.word_gap_ticks   <= RESET_WORD_GAP_TICKS;
            result_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // The result payload is only loaded with a beat, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= step_result;
        end
    end

    mck_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fifo_ctl),
        .push_data (char_byte),
        .head      (fifo_head),
        .count     (fifo_count)
    );

    mck_keyer #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_keyer (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .opcode        (opcode),
        .last_of_write (last_of_write),
        .cfg           (cfg_reg),
        .fifo_count    (fifo_count),
        .fifo_head     (fifo_head),
        .fifo_ctl      (fifo_ctl),
        .result        (step_result)
    );

    assign result_valid = result_valid_reg;
    assign key_on       = result_reg.key_on;
    assign accepted     = result_reg.accepted;
    assign busy_res     = result_reg.busy_res;
    assign fifo_level   = result_reg.fifo_level;

endmodule
`default_nettype wire

### rtl/core/mck_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Morse keyer port checker
// Concurrent assertions on the ports of the keyer unit, bound to its top.
// ============================================================================
module mck_port_checker
    import mck_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       item_valid,
    input wire logic                       item_ready,
    input wire logic                       opcode,
    input wire logic                       result_valid,
    input wire logic                       result_ready,
    input wire logic                       key_on,
    input wire logic                       accepted,
    input wire logic                       busy_res,
    input wire logic [LEVEL_WIDTH-1:0]     fifo_level
);

    // With no result pending the unit must take a beat.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item_ready low with no result pending");

    // Every accepted beat shows a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("no result after an accepted beat");

    // A tick never reports a queued byte.
    a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && opcode == OP_TICK |=> !accepted)
        else $error("tick beat reported as accepted");

    // The key is only on while sending.
    a_key_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !key_on || busy_res)
        else $error("key on while not busy");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(fifo_level) && $stable(key_on))
        else $error("stalled result changed");

endmodule

bind morse_code_keyer_unit mck_port_checker u_port_checker (.*);
`default_nettype wire

### verif/morse_code_keyer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Morse code keyer unit testbench
// Drives write and tick beats into the keyer, predicts every result beat with
// an independent model of the FIFO and keying sequence, and compares each
// result field by field under several timing settings and idling patterns.
// ============================================================================
module morse_code_keyer_unit_tb;
    import mck_pkg::*;

    localparam int FIFO_DEPTH  = DEFAULT_FIFO_DEPTH;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_BEATS = 120;
    localparam int TIMING_REGS = 5;

    // One input beat as the sender presents it.
    typedef struct packed {
        logic                  op;
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } keyer_beat_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       item_valid    = 1'b0;
    logic                       item_ready;
    logic                       opcode        = OP_WRITE;
    logic [CHAR_WIDTH-1:0]      char_byte     = '0;
    logic                       last_of_write = 1'b0;
    logic                       result_valid;
    logic                       result_ready  = 1'b0;
    logic                       key_on;
    logic                       accepted;
    logic                       busy_res;
    logic [LEVEL_WIDTH-1:0]     fifo_level;
    logic                       cfg_write     = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [CFG_WIDTH-1:0]       cfg_data      = '0;

    morse_code_keyer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .char_byte    (char_byte),
        .last_of_write(last_of_write),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .key_on       (key_on),
        .accepted     (accepted),
        .busy_res     (busy_res),
        .fifo_level   (fifo_level),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Stimulus and scoreboard storage.
    // ------------------------------------------------------------------------
    keyer_beat_t outgoing_beats [$];    // beats waiting for the driver
    keyer_beat_t beat_on_bus;           // beat currently offered to the block
    mck_result_t expected_results [$];  // predicted results, oldest first

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int cycle_count     = 0;

    int failures       = 0;
    int beats_taken    = 0;
    int results_seen   = 0;
    int refused_writes = 0;
    int glyphs_keyed   = 0;

    // ------------------------------------------------------------------------
    // Keyer prediction state: a private copy of the character FIFO, the
    // keying sequencer and the five timing registers.
    // ------------------------------------------------------------------------
    logic [CHAR_WIDTH-1:0] fifo_copy [FIFO_DEPTH];
    int                    wr_slot;
    int                    rd_slot;
    int                    chars_waiting;
    logic                  keyer_busy;
    logic                  key_down;
    logic                  mid_letter;
    logic [4:0]            letter_bits;
    logic [2:0]            letter_len;
    logic [2:0]            next_symbol;
    int                    ticks_left;
    logic [CFG_WIDTH-1:0]  timing [TIMING_REGS];

    // International Morse code, letters A to Z, then digits 0 to 9. The
    // pattern bits are derived from these strings rather than taken from the
    // table in the package, so a wrong table entry shows up as a mismatch.
    string glyph_code [GLYPH_COUNT] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    // A zero setting lasts one tick. The registers are as wide as the tick
    // counter, so no setting ever needs to saturate.
    function automatic int ticks_for(input logic [CFG_WIDTH-1:0] setting);
        return (setting == '0) ? 1 : int'(setting);
    endfunction

    // Keys the next dot or dash of the current letter.
    task automatic key_next_symbol();
        key_down   = 1'b1;
        ticks_left = ticks_for(letter_bits[next_symbol] ? timing[CFG_DASH_TICKS]
                                                        : timing[CFG_DOT_TICKS]);
        next_symbol = next_symbol + 3'd1;
    endtask

    // Advances the predicted keyer by one accepted beat and returns the
    // result beat that the block must produce for it.
    task automatic predict_keyer(input keyer_beat_t b, output mck_result_t r);
        logic [CHAR_WIDTH-1:0] c;
        int                    slot;
        string                 code;
        r = '0;
        if (b.op == OP_WRITE) begin
            if (chars_waiting < FIFO_DEPTH) begin
                fifo_copy[wr_slot] = b.ch;
                wr_slot            = (wr_slot + 1) % FIFO_DEPTH;
                chars_waiting++;
                r.accepted = 1'b1;
            end else begin
                refused_writes++;
            end
            // Even a refused last byte starts an idle keyer that has data.
            if (b.last && !keyer_busy && chars_waiting > 0) begin
                keyer_busy = 1'b1;
                ticks_left = 1;
            end
        end else if (keyer_busy) begin
            if (ticks_left > 0)
                ticks_left--;
            if (ticks_left == 0) begin
                if (!mid_letter) begin
                    if (chars_waiting == 0) begin
                        keyer_busy = 1'b0;
                        key_down   = 1'b0;
                    end else begin
                        c       = fifo_copy[rd_slot];
                        rd_slot = (rd_slot + 1) % FIFO_DEPTH;
                        chars_waiting--;
                        slot = -1;
                        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                            slot = int'(c - CHAR_UPPER_A);
                        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                            slot = int'(c - CHAR_LOWER_A);
                        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
                            slot = 26 + int'(c - CHAR_DIGIT_0);
                        if (slot >= 0) begin
                            code        = glyph_code[slot];
                            letter_bits = '0;
                            letter_len  = 3'(code.len());
                            for (int i = 0; i < code.len(); i++)
                                letter_bits[i] = (code[i] == "-");
                            next_symbol = '0;
                            mid_letter  = 1'b1;
                            glyphs_keyed++;
                            key_next_symbol();
                        end else if (c == CHAR_SPACE) begin
                            key_down   = 1'b0;
                            ticks_left = ticks_for(timing[CFG_WORD_GAP_TICKS]);
                        end else begin
                            // Punctuation and bytes at or above 128 just cost a tick.
                            ticks_left = 1;
                        end
                    end
                end else if (key_down) begin
                    key_down   = 1'b0;
                    ticks_left = ticks_for(timing[CFG_SYMBOL_GAP_TICKS]);
                end else if (next_symbol >= letter_len) begin
                    ticks_left = ticks_for(timing[CFG_LETTER_GAP_TICKS]);
                    mid_letter = 1'b0;
                end else begin
                    key_next_symbol();
                end
            end
        end
        r.key_on     = key_down;
        r.busy_res   = keyer_busy;
        r.fifo_level = LEVEL_WIDTH'(chars_waiting);
    endtask

    // ------------------------------------------------------------------------
    // Clock and the run limit. The limit is far above the slowest correct
    // run, so hitting it means the block has hung or lost beats.
    // ------------------------------------------------------------------------
    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run limit of %0d cycles reached, %0d results still expected",
                     CYCLE_LIMIT, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver. On every accepted beat the prediction is taken, then the next
    // pending beat is offered unless the sender decides to idle this cycle.
    // Valid is only ever lowered when nothing is left on the bus.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : item_driver
        mck_result_t want;
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (item_valid && item_ready) begin
                predict_keyer(beat_on_bus, want);
                expected_results.push_back(want);
                beats_taken++;
            end
            if (!item_valid || item_ready) begin
                if (outgoing_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat_on_bus    = outgoing_beats.pop_front();
                    item_valid    <= 1'b1;
                    opcode        <= beat_on_bus.op;
                    char_byte     <= beat_on_bus.ch;
                    last_of_write <= beat_on_bus.last;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result beat is checked against the oldest prediction.
    // Ready is randomized per cycle, except during a requested hold-off, when it
    // stays low while hold_left runs down, so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : result_monitor
        mck_result_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (key_on !== want.key_on) begin
                        $error("key_on: expected %0d, got %0d", want.key_on, key_on);
                        failures++;
                    end
                    if (accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, accepted);
                        failures++;
                    end
                    if (busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, busy_res);
                        failures++;
                    end
                    if (fifo_level !== want.fifo_level) begin
                        $error("fifo_level: expected %0d, got %0d",
                               want.fifo_level, fifo_level);
                        failures++;
                    end
                end
            end
            if (holds_served != holds_requested) begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end else begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers.
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic op, input logic [CHAR_WIDTH-1:0] ch,
                              input logic last);
        outgoing_beats.push_back(keyer_beat_t'{op, ch, last});
    endtask

    // Returns once every queued beat has been taken and every result checked.
    task automatic wait_results_done();
        while (outgoing_beats.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Ticks the keyer until it has stopped with an empty FIFO, so that the
    // timing registers can be rewritten with nothing in flight. An idle keyer
    // still holding characters is kicked off with one more last byte.
    task automatic settle_keyer();
        int burst;
        while (1) begin
            wait_results_done();
            if (!keyer_busy && chars_waiting == 0)
                break;
            if (!keyer_busy)
                queue_beat(OP_WRITE, 8'h23, 1'b1);
            burst = ticks_left + 8;
            repeat (burst) queue_beat(OP_TICK, 8'h00, 1'b0);
        end
        repeat (3) @(posedge clk);
    endtask

    // Writes all five timing registers, one per cycle, then pokes a register
    // index past the end, which the block has to ignore.
    task automatic program_timing(input logic [CFG_WIDTH-1:0] dot, dash, sgap, lgap, wgap);
        logic [CFG_INDEX_WIDTH-1:0] idx [TIMING_REGS];
        logic [CFG_WIDTH-1:0]       val [TIMING_REGS];
        idx = '{CFG_DOT_TICKS, CFG_DASH_TICKS, CFG_SYMBOL_GAP_TICKS,
                CFG_LETTER_GAP_TICKS, CFG_WORD_GAP_TICKS};
        val = '{dot, dash, sgap, lgap, wgap};
        for (int i = 0; i < TIMING_REGS; i++) begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            timing[idx[i]] = val[i];
        end
        @(posedge clk);
        cfg_index <= CFG_WORD_GAP_TICKS + CFG_INDEX_WIDTH'(1 + $urandom_range(2));
        cfg_data  <= CFG_WIDTH'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Random traffic. Most of it is whole words closed by a last byte and
    // followed by a run of ticks, so letters are really keyed out; the rest
    // is stray ticks and writes with random bytes and random last flags.
    task automatic queue_traffic(input int quota);
        int                    made;
        int                    kind;
        int                    n;
        logic [CHAR_WIDTH-1:0] c;
        made = 0;
        while (made < quota) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(9))
                        0, 1:    c = CHAR_UPPER_A + CHAR_WIDTH'($urandom_range(25));
                        2, 3:    c = CHAR_LOWER_A + CHAR_WIDTH'($urandom_range(25));
                        4, 5:    c = CHAR_DIGIT_0 + CHAR_WIDTH'($urandom_range(9));
                        6:       c = CHAR_SPACE;
                        default: c = CHAR_WIDTH'($urandom);
                    endcase
                    queue_beat(OP_WRITE, c, i == n - 1);
                end
                made += n;
                n = $urandom_range(4, 30 * n);
                // Char and last are don't-care on ticks, so they carry noise.
                repeat (n) queue_beat(OP_TICK, CHAR_WIDTH'($urandom), 1'($urandom));
                made += n;
            end else if (kind < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) queue_beat(OP_TICK, CHAR_WIDTH'($urandom), 1'($urandom));
                made += n;
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) queue_beat(OP_WRITE, CHAR_WIDTH'($urandom), 1'($urandom));
                made += n;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        logic [CFG_WIDTH-1:0] pick [TIMING_REGS];

        // Prediction state matches the block right after reset.
        wr_slot       = 0;
        rd_slot       = 0;
        chars_waiting = 0;
        keyer_busy    = 1'b0;
        key_down      = 1'b0;
        mid_letter    = 1'b0;
        letter_bits   = '0;
        letter_len    = '0;
        next_symbol   = '0;
        ticks_left    = 0;
        timing[CFG_DOT_TICKS]        = RESET_DOT_TICKS;
        timing[CFG_DASH_TICKS]       = RESET_DASH_TICKS;
        timing[CFG_SYMBOL_GAP_TICKS] = RESET_SYMBOL_GAP_TICKS;
        timing[CFG_LETTER_GAP_TICKS] = RESET_LETTER_GAP_TICKS;
        timing[CFG_WORD_GAP_TICKS]   = RESET_WORD_GAP_TICKS;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on the reset timing: an idle tick, a byte queued
        // without starting, the start, then the edges of every character
        // class, a space, punctuation, bytes at or above 128 and a last byte
        // that arrives while the keyer is already busy.
        queue_beat(OP_TICK,  8'h00, 1'b1);
        queue_beat(OP_WRITE, CHAR_UPPER_A, 1'b0);
        queue_beat(OP_TICK,  8'hFF, 1'b0);
        queue_beat(OP_WRITE, CHAR_LOWER_Z, 1'b1);
        queue_beat(OP_TICK,  8'h00, 1'b0);
        queue_beat(OP_WRITE, CHAR_DIGIT_0, 1'b0);
        queue_beat(OP_WRITE, CHAR_DIGIT_9, 1'b0);
        queue_beat(OP_WRITE, CHAR_UPPER_Z, 1'b0);
        queue_beat(OP_WRITE, CHAR_LOWER_A, 1'b0);
        queue_beat(OP_WRITE, CHAR_SPACE,   1'b0);
        queue_beat(OP_WRITE, 8'h7E, 1'b0);
        queue_beat(OP_WRITE, 8'h80, 1'b0);
        queue_beat(OP_WRITE, 8'hFF, 1'b0);
        queue_beat(OP_WRITE, 8'h00, 1'b0);
        queue_beat(OP_WRITE, 8'h40, 1'b0);
        queue_beat(OP_WRITE, 8'h5B, 1'b0);
        queue_beat(OP_WRITE, 8'h60, 1'b0);
        queue_beat(OP_WRITE, 8'h7B, 1'b0);
        queue_beat(OP_WRITE, 8'h2F, 1'b0);
        queue_beat(OP_WRITE, 8'h3A, 1'b1);
        repeat (3) queue_beat(OP_TICK, 8'h00, 1'b0);
        // The first dot runs out on its reset length; everything after it is
        // keyed on zero settings so the queue drains in a few hundred ticks.
        wait_results_done();
        program_timing('0, '0, '0, '0, '0);
        settle_keyer();

        // Zero settings must behave as one tick. With the keyer this fast,
        // fill the FIFO to the brim without starting it; the refused last
        // byte still has to start sending. Once the first tick pops a byte,
        // one more write fits and the next is refused again. The fill bytes
        // are all at or above 128, so each one drains in a single tick.
        program_timing('0, '0, '0, '0, '0);
        for (int i = 0; i < FIFO_DEPTH; i++)
            queue_beat(OP_WRITE, CHAR_WIDTH'($urandom_range(128, 255)), 1'b0);
        queue_beat(OP_WRITE, CHAR_WIDTH'($urandom), 1'b1);
        queue_beat(OP_WRITE, CHAR_WIDTH'($urandom), 1'b0);
        queue_beat(OP_TICK,  8'h00, 1'b0);
        queue_beat(OP_WRITE, CHAR_UPPER_A + 8'd4, 1'b1);
        queue_beat(OP_WRITE, CHAR_UPPER_A + 8'd19, 1'b0);
        settle_keyer();

        // Random phases, each with its own timing and idling pattern.
        for (int phase = 0; phase < 4; phase++) begin
            for (int r = 0; r < TIMING_REGS; r++)
                pick[r] = CFG_WIDTH'($urandom_range(1, phase == 1 ? 6 : 4));
            if (phase == 2)
                pick = '{16'd1, 16'd3, 16'd1, 16'd3, 16'd7};
            program_timing(pick[0], pick[1], pick[2], pick[3], pick[4]);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (phase == 2) begin
                // Long receiver hold-off while the sender keeps offering beats.
                queue_traffic(PHASE_BEATS);
                holds_requested++;
            end else if (phase == 1) begin
                // Sender stops halfway until every result is back.
                queue_traffic(PHASE_BEATS / 2);
                wait_results_done();
                queue_traffic(PHASE_BEATS / 2);
            end else begin
                queue_traffic(PHASE_BEATS);
            end
            settle_keyer();
        end

        // Every register at its largest setting. Only the first dot is keyed
        // here; the run ends without waiting the long intervals out.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_beat(OP_WRITE, CHAR_UPPER_A + 8'd4, 1'b0);
        queue_beat(OP_WRITE, CHAR_SPACE, 1'b1);
        repeat (40) queue_beat(OP_TICK, 8'h00, 1'b0);

        wait_results_done();
        repeat (10) @(posedge clk);

        $display("Covered %0d beats and %0d checked results: %0d refused writes, %0d glyphs keyed.",
                 beats_taken, results_seen, refused_writes, glyphs_keyed);
        $display("Timing went through reset values, all zero, small random and all maximum.");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
